/* sv/utd_pkg.sv */
// Shared types and constants for the UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps
package utd_pkg;

    // Default depth of the job queue between front and back
    localparam int unsigned UTD_FIFO_DEPTH = 4;

    // Byte class tags, compared against the top bits of a byte
    localparam logic [1:0] TAG_CONT  = 2'b10;     // 10xxxxxx
    localparam logic [2:0] TAG_LEAD2 = 3'b110;    // one continuation byte
    localparam logic [3:0] TAG_LEAD3 = 4'b1110;   // two
    localparam logic [4:0] TAG_LEAD4 = 5'b11110;  // three
    localparam logic [5:0] TAG_LEAD5 = 6'b111110; // four
    localparam logic [6:0] TAG_LEAD6 = 7'b1111110; // five

    // Surrogate bases and pair offset
    localparam logic [15:0] SURR_HIGH_BASE = 16'hD800;
    localparam logic [15:0] SURR_LOW_BASE  = 16'hDC00;
    localparam logic [19:0] PAIR_OFFSET    = 20'h10000;

    // One decoded job handed from front to back
    typedef struct packed {
        logic        pair;  // value above 0xFFFF, emit a surrogate pair
        logic        term;  // zero terminator
        logic [19:0] value; // low 20 bits of the code point
    } t_job;

endpackage

/* sv/utd_front.sv */
// Front end: classifies each byte, gathers sequence bits, issues jobs.
`timescale 1ns / 1ps
module utd_front
    import utd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte_in,
    output logic       o_job_valid,
    output t_job       o_job
);

    logic [19:0] r_acc;   // low 20 payload bits gathered so far
    logic        r_hi;    // some payload bit above bit 19 was set
    logic [2:0]  r_rem;   // continuation bytes still expected

    logic [19:0] n_acc;
    logic        n_hi;
    logic [2:0]  n_rem;
    logic [19:0] cont_acc;
    logic        cont_hi;

    // Shift six payload bits in, remembering anything pushed past bit 19
    assign cont_acc = {r_acc[13:0], i_byte_in[5:0]};
    assign cont_hi  = r_hi | (|r_acc[19:14]);

    // Decode the byte against the open sequence
    always_comb begin
        n_acc       = r_acc;
        n_hi        = r_hi;
        n_rem       = r_rem;
        o_job_valid = 1'b0;
        o_job       = '{pair: 1'b0, term: 1'b0, value: '0};
        if (i_accept) begin
            priority if (i_byte_in == 8'h00) begin
                n_acc       = '0;
                n_hi        = 1'b0;
                n_rem       = '0;
                o_job_valid = 1'b1;
                o_job.term  = 1'b1;
            end else if (r_rem != 3'd0 && i_byte_in[7:6] == TAG_CONT) begin
                n_acc = cont_acc;
                n_hi  = cont_hi;
                n_rem = r_rem - 3'd1;
                if (r_rem == 3'd1) begin
                    n_acc       = '0;
                    n_hi        = 1'b0;
                    o_job_valid = 1'b1;
                    o_job.value = cont_acc;
                    o_job.pair  = cont_hi | (|cont_acc[19:16]);
                end
            end else begin
                // Fresh byte: any open sequence is dropped
                n_acc = '0;
                n_hi  = 1'b0;
                n_rem = '0;
                priority if (i_byte_in[7] == 1'b0) begin
                    o_job_valid = 1'b1;
                    o_job.value = {12'd0, i_byte_in};
                end else if (i_byte_in[7:5] == TAG_LEAD2) begin
                    n_acc = {15'd0, i_byte_in[4:0]};
                    n_rem = 3'd1;
                end else if (i_byte_in[7:4] == TAG_LEAD3) begin
                    n_acc = {16'd0, i_byte_in[3:0]};
                    n_rem = 3'd2;
                end else if (i_byte_in[7:3] == TAG_LEAD4) begin
                    n_acc = {17'd0, i_byte_in[2:0]};
                    n_rem = 3'd3;
                end else if (i_byte_in[7:2] == TAG_LEAD5) begin
                    n_acc = {18'd0, i_byte_in[1:0]};
                    n_rem = 3'd4;
                end else if (i_byte_in[7:1] == TAG_LEAD6) begin
                    n_acc = {19'd0, i_byte_in[0]};
                    n_rem = 3'd5;
                end else begin
                    // Stray continuation, 0xFE or 0xFF: drop
                    n_rem = '0;
                end
            end
        end
    end

    // Hold sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_hi  <= 1'b0;
            r_rem <= '0;
        end else begin
            r_acc <= n_acc;
            r_hi  <= n_hi;
            r_rem <= n_rem;
        end
    end

endmodule

/* sv/utd_fifo.sv */
// Short job queue between the front and back ends.
`timescale 1ns / 1ps
module utd_fifo
    import utd_pkg::*;
#(
    parameter int unsigned DEPTH = UTD_FIFO_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    input  logic i_pop,
    output t_job o_data,
    output logic o_empty,
    output logic o_full
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_empty = (r_count == CW'(0));
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Write the entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

/* sv/utd_back.sv */
// Back end: turns jobs into UTF-16 units in an output register.
`timescale 1ns / 1ps
module utd_back
    import utd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_job,
    input  logic        i_job_empty,
    output logic        o_job_pop,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [15:0] o_code_unit,
    output logic        o_run_end,
    output logic        o_string_end
);

    typedef enum logic {
        PH_FIRST,
        PH_SECOND
    } t_phase;

    t_phase      r_phase;
    logic        r_valid;
    logic [15:0] r_unit;
    logic        r_run_end;
    logic        r_str_end;

    logic        out_free;
    logic [19:0] pair_val;
    logic [15:0] high_unit;
    logic [15:0] low_unit;

    // Split the value above 0xFFFF into two surrogates
    assign pair_val  = i_job.value - PAIR_OFFSET;
    assign high_unit = SURR_HIGH_BASE + {6'd0, pair_val[19:10]};
    assign low_unit  = SURR_LOW_BASE + {6'd0, pair_val[9:0]};

    assign out_free  = !r_valid || i_pop;
    assign o_job_pop = out_free && !i_job_empty &&
                       (r_phase == PH_SECOND || !i_job.pair);

    // Load the output register from the head job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_FIRST;
            r_valid   <= 1'b0;
            r_unit    <= '0;
            r_run_end <= 1'b0;
            r_str_end <= 1'b0;
        end else if (out_free) begin
            if (i_job_empty) begin
                r_valid <= 1'b0;
            end else begin
                r_valid <= 1'b1;
                unique case (r_phase)
                    PH_FIRST: begin
                        if (i_job.pair) begin
                            r_unit    <= high_unit;
                            r_run_end <= 1'b0;
                            r_str_end <= 1'b0;
                            r_phase   <= PH_SECOND;
                        end else begin
                            r_unit    <= i_job.value[15:0];
                            r_run_end <= 1'b1;
                            r_str_end <= i_job.term;
                        end
                    end
                    PH_SECOND: begin
                        r_unit    <= low_unit;
                        r_run_end <= 1'b1;
                        r_str_end <= 1'b0;
                        r_phase   <= PH_FIRST;
                    end
                    default: r_phase <= PH_FIRST;
                endcase
            end
        end
    end

    assign o_empty      = !r_valid;
    assign o_code_unit  = r_unit;
    assign o_run_end    = r_run_end;
    assign o_string_end = r_str_end;

endmodule

/* sv/utf8_to_utf16_decoder.sv */
// Top level of the UTF-8 to UTF-16 stream decoder.
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+-----------------------------------------
//  byte in  | i_push / o_full        | i_byte_in[7:0]
//  unit out | o_empty / i_pop        | o_code_unit[15:0], o_run_end, o_string_end
//
// One byte is taken every cycle while the job queue has room; the front end
// decodes it in that cycle. The back end issues one unit a cycle from its
// output register while units are popped, so a surrogate pair occupies it
// for both its units and the queue absorbs the delay. Reset needs no clearing
// pass. A stall on the output fills the queue and then raises o_full.
`timescale 1ns / 1ps
module utf8_to_utf16_decoder
    import utd_pkg::*;
#(
    parameter int unsigned FifoDepth = UTD_FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_byte_in,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [15:0] o_code_unit,
    output logic        o_run_end,
    output logic        o_string_end
);

    logic accept;
    logic job_valid;
    t_job job_in;
    t_job job_head;
    logic job_empty;
    logic job_pop;

    assign accept = i_push && !o_full;

    // Classify and gather bytes
    utd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte_in   (i_byte_in),
        .o_job_valid (job_valid),
        .o_job       (job_in)
    );

    // Queue jobs between the two ends
    utd_fifo #(
        .DEPTH (FifoDepth)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_data  (job_in),
        .i_pop   (job_pop),
        .o_data  (job_head),
        .o_empty (job_empty),
        .o_full  (o_full)
    );

    // Emit units
    utd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (job_head),
        .i_job_empty  (job_empty),
        .o_job_pop    (job_pop),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_code_unit  (o_code_unit),
        .o_run_end    (o_run_end),
        .o_string_end (o_string_end)
    );

    // Terminator is a zero unit that closes its run
    a_term_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_string_end) |-> (o_code_unit == 16'd0 && o_run_end))
        else $error("terminator unit malformed");

    // A unit that does not close its run is a high surrogate
    a_high_surr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_run_end) |-> (o_code_unit[15:10] == SURR_HIGH_BASE[15:10]))
        else $error("open run on a non high surrogate unit");

    // A popped high surrogate is followed at once by its low half
    a_low_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_run_end && i_pop) |=>
            (!o_empty && o_run_end && o_code_unit[15:10] == SURR_LOW_BASE[15:10]))
        else $error("low surrogate missing after high surrogate");

    // Reset leaves both sides idle
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_full && o_empty))
        else $error("not idle after reset");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the UTF-8 to UTF-16 stream decoder.
`timescale 1ns / 1ps
module testbench;
    import utd_pkg::*;

    localparam int unsigned CycleLimit  = 200000;
    localparam int unsigned DrainCycles = 10;

    // One UTF-16 unit as it leaves the decoder
    typedef struct packed {
        logic [15:0] code_unit;
        logic        run_end;
        logic        string_end;
    } t_unit;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_push    = 1'b0;
    logic [7:0]  i_byte_in = 8'h00;
    logic        i_pop     = 1'b0;
    logic        o_full;
    logic        o_empty;
    logic [15:0] o_code_unit;
    logic        o_run_end;
    logic        o_string_end;

    // Units still owed by the decoder, oldest first
    t_unit       pending_units[$];

    // Shadow of the decoder's sequence state
    logic [31:0] seq_value = '0;
    logic [2:0]  seq_left  = '0;

    bit          tx_idle_on  = 1'b1;
    bit          rx_idle_on  = 1'b1;
    int          hold_req    = 0;
    int          hold_left   = 0;
    int          fail_count  = 0;
    int          bytes_sent  = 0;
    int          units_seen  = 0;
    int          pairs_seen  = 0;
    int          terms_seen  = 0;
    int          full_stalls = 0;
    int unsigned cycle_count = 0;

    utf8_to_utf16_decoder uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_byte_in    (i_byte_in),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_code_unit  (o_code_unit),
        .o_run_end    (o_run_end),
        .o_string_end (o_string_end)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void add_unit(input logic [15:0] unit, input logic last,
                                     input logic term);
        pending_units.push_back(t_unit'{code_unit: unit, run_end: last, string_end: term});
    endfunction

    // Work out the units that one accepted byte causes
    function automatic void decode_byte(input logic [7:0] b);
        logic [31:0] done_value;
        logic [31:0] offset;
        int          extra;
        if (b == 8'h00) begin
            seq_value = '0;
            seq_left  = '0;
            add_unit(16'h0000, 1'b1, 1'b1);
            return;
        end
        if (seq_left != 3'd0) begin
            if (b[7:6] == TAG_CONT) begin
                seq_value = {seq_value[25:0], b[5:0]};
                seq_left  = seq_left - 3'd1;
                if (seq_left == 3'd0) begin
                    done_value = seq_value;
                    seq_value  = '0;
                    if (done_value <= 32'h0000_FFFF) begin
                        add_unit(done_value[15:0], 1'b1, 1'b0);
                    end else begin
                        // split into a pair, dropping bits above bit 19
                        offset = done_value - 32'h0001_0000;
                        add_unit(SURR_HIGH_BASE + {6'd0, offset[19:10]}, 1'b0, 1'b0);
                        add_unit(SURR_LOW_BASE + {6'd0, offset[9:0]}, 1'b1, 1'b0);
                    end
                end
                return;
            end
            // broken sequence: drop it, then treat the byte as fresh
            seq_value = '0;
            seq_left  = '0;
        end
        if (!b[7]) begin
            add_unit({8'h00, b}, 1'b1, 1'b0);
            return;
        end
        if (b[7:5] == TAG_LEAD2) begin
            extra = 1;
        end else if (b[7:4] == TAG_LEAD3) begin
            extra = 2;
        end else if (b[7:3] == TAG_LEAD4) begin
            extra = 3;
        end else if (b[7:2] == TAG_LEAD5) begin
            extra = 4;
        end else if (b[7:1] == TAG_LEAD6) begin
            extra = 5;
        end else begin
            // stray continuation, 0xFE or 0xFF: skipped
            return;
        end
        seq_value = {24'd0, b} & ((32'd1 << (7 - extra)) - 32'd1);
        seq_left  = 3'(extra);
    endfunction

    // Offer one item, idling first at random, and hold it until taken
    task automatic send_byte(input logic [7:0] b);
        while (tx_idle_on && $urandom_range(99) < 12) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push    <= 1'b1;
        i_byte_in <= b;
        @(posedge i_clk);
        while (o_full) begin
            full_stalls++;
            @(posedge i_clk);
        end
        decode_byte(b);
        bytes_sent++;
    endtask

    // Drop push for one cycle so that the next raise falls in a later step
    task automatic pause_input();
        i_push <= 1'b0;
        @(posedge i_clk);
    endtask

    // Send a sequence of len bytes with random payload; a cut one stops
    // early and ends on a byte that is not a continuation
    task automatic send_sequence(input int len, input bit cut);
        logic [7:0] lead;
        logic [7:0] breaker;
        int         keep;
        if (len == 1) begin
            send_byte(8'($urandom_range(127, 1)));
            return;
        end
        lead = ~(8'hFF >> len) | (8'($urandom) & (8'hFF >> (len + 1)));
        keep = cut ? $urandom_range(len - 2, 0) : len - 1;
        send_byte(lead);
        repeat (keep) send_byte({TAG_CONT, 6'($urandom)});
        if (cut) begin
            breaker = 8'($urandom);
            if (breaker[7:6] == TAG_CONT)
                breaker[6] = 1'b1;
            send_byte(breaker);
        end
    endtask

    // Every lead length, at the 16-bit edge and beyond the 21-bit range
    task automatic test_sequence_lengths();
        logic [7:0] seq_bytes[] = '{8'hDF, 8'hBF,
                                    8'hEF, 8'hBF, 8'hBF,
                                    8'hF4, 8'h8F, 8'hBF, 8'hBF,
                                    8'hF8, 8'h88, 8'h80, 8'h80, 8'h80,
                                    8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF};
        foreach (seq_bytes[n])
            send_byte(seq_bytes[n]);
        pause_input();
    endtask

    // Broken sequence, stray continuation, the two invalid bytes and a
    // terminator inside an open sequence
    task automatic test_malformed_bytes();
        logic [7:0] odd_bytes[] = '{8'hE2, 8'h7F, 8'h80, 8'hFE, 8'hFF, 8'hE2, 8'h00};
        foreach (odd_bytes[n])
            send_byte(odd_bytes[n]);
        pause_input();
    endtask

    // Mostly well-formed text with random content, plus cuts, ends and noise
    task automatic test_random_stream(input int count);
        int start;
        int pick;
        start = bytes_sent;
        while (bytes_sent - start < count) begin
            pick = $urandom_range(99);
            if (pick < 65)
                send_sequence($urandom_range(6, 1), 1'b0);
            else if (pick < 75)
                send_byte(8'h00);
            else if (pick < 90)
                send_sequence($urandom_range(6, 2), 1'b1);
            else
                send_byte(8'($urandom));
        end
        pause_input();
    endtask

    // Back-to-back traffic with both sides always ready
    task automatic test_full_rate(input int count);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_stream(count);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Hold the output off for a long stretch while bytes keep coming
    task automatic test_output_stall(input int count);
        tx_idle_on = 1'b0;
        hold_req   = 80;
        test_random_stream(count);
        tx_idle_on = 1'b1;
    endtask

    // Take units, compare each with the oldest one owed, then pick next pop
    always @(posedge i_clk) begin : unit_check
        t_unit want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (pending_units.size() == 0) begin
                $error("unexpected unit %h (run_end %b, string_end %b)",
                       o_code_unit, o_run_end, o_string_end);
                fail_count++;
            end else begin
                want = pending_units.pop_front();
                if (o_code_unit !== want.code_unit) begin
                    $error("code_unit: expected %h, got %h", want.code_unit, o_code_unit);
                    fail_count++;
                end
                if (o_run_end !== want.run_end) begin
                    $error("run_end: expected %b, got %b", want.run_end, o_run_end);
                    fail_count++;
                end
                if (o_string_end !== want.string_end) begin
                    $error("string_end: expected %b, got %b", want.string_end,
                           o_string_end);
                    fail_count++;
                end
            end
            units_seen++;
            if (!o_run_end)
                pairs_seen++;
            if (o_string_end)
                terms_seen++;
        end
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_pop <= 1'b0;
        end else begin
            i_pop <= !(rx_idle_on && $urandom_range(99) < 12);
        end
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("Timed out after %0d cycles with %0d units owed", CycleLimit,
                     pending_units.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_sequence_lengths();
        test_malformed_bytes();
        test_random_stream(430);
        test_full_rate(100);
        test_output_stall(90);

        // Drain what is still owed, then allow for stragglers
        while (pending_units.size() != 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("Covered %0d bytes in, %0d units out, %0d surrogate pairs, %0d terminators",
                 bytes_sent, units_seen, pairs_seen, terms_seen);
        $display("Input held off by a full queue on %0d cycles", full_stalls);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
